// File: sv/stlb_pkg.sv
// Shared types and constants for the sorted-table lower-bound search block.
`default_nettype none

package stlb_pkg;

    // Item field widths
    localparam int FUNC_W  = 1;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 11;
    localparam int COUNT_W = 11;

    // Stream bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = ((INDEX_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

    // Parameter defaults
    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Item kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    // Table port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    // Search engine status
    typedef struct packed {
        logic busy;
        logic res_valid;
    } srch_stat_t;

endpackage

`default_nettype wire

// File: sv/sorted_table_lower_bound.sv
// Top level: sorted table with lower-bound binary search over a stream interface.
//
//  channel | signals                           | direction | content
//  --------+-----------------------------------+-----------+-------------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser | in        | write or query item
//  m       | m_tvalid m_tready m_tdata         | out       | position result per query
//  cfg     | cfg_valid cfg_ready cfg_data      | in        | entry_count register
//
//  Write items: the table is written on the accept edge.
//  A query runs the PROBE and CMP states of the search once per probe, with at most
//  clog2(entry_count) + 1 probes; the single table read port serves one probe at a
//  time, and the result then waits in the DONE state until it can move on.
//  The finished result sits in the m-side output register; the next item is
//  accepted once the result has moved there, even if m_tready is low.
//  rst_n (async, active low) clears control and entry_count; table contents
//  are undefined until written.
`default_nettype none

module sorted_table_lower_bound #(
    parameter int DEPTH      = stlb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = stlb_pkg::DATA_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // slave side
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [stlb_pkg::IN_TDATA_W-1:0]     s_tdata,   // index[9:0], value[41:10], zero pad
    input  wire  [stlb_pkg::FUNC_W-1:0]         s_tuser,   // func[0]: 0 write, 1 query
    // master side
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [stlb_pkg::OUT_TDATA_W-1:0]    m_tdata,   // position[10:0], zero pad
    // configuration
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [stlb_pkg::COUNT_W-1:0]        cfg_data   // entry_count[10:0]
);

    import stlb_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);

    // Input unpack
    logic [INDEX_W-1:0]    s_index;
    logic [VALUE_W-1:0]    s_value;
    logic                  s_accept;
    logic                  wr_hit;
    logic                  query_start;

    // Config register
    logic [COUNT_W-1:0]    entry_count_reg;
    logic [31:0]           count_ext;
    logic [CW-1:0]         count_sat;

    // Table / search connections
    mem_ctrl_t             mem_ctrl;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    srch_stat_t            stat;
    logic [CW-1:0]         search_pos;
    logic                  res_ready;

    // Output register
    logic                  m_valid_reg;
    logic [POS_W-1:0]      m_pos_reg;

    assign s_index  = s_tdata[INDEX_W-1:0];
    assign s_value  = s_tdata[INDEX_W +: VALUE_W];
    assign s_tready = !stat.busy;
    assign s_accept = s_tvalid && s_tready;

    // Writes beyond the table depth are dropped
    assign wr_hit      = s_accept && (s_tuser == FUNC_WRITE) && (32'(s_index) < 32'(DEPTH));
    assign query_start = s_accept && (s_tuser == FUNC_QUERY);

    // entry_count saturates at the table depth
    assign count_ext = 32'(entry_count_reg);
    assign count_sat = (count_ext > 32'(DEPTH)) ? CW'(DEPTH) : CW'(count_ext);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    assign mem_ctrl.wr_en = wr_hit;
    assign mem_ctrl.rd_en = rd_en;

    stlb_table #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_table (
        .clk     (clk),
        .ctrl    (mem_ctrl),
        .wr_addr (ADDR_W'(s_index)),
        .wr_data (DATA_WIDTH'(s_value)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stlb_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (query_start),
        .key       (DATA_WIDTH'(s_value)),
        .count     (count_sat),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_ready (res_ready),
        .stat      (stat),
        .position  (search_pos)
    );

    // Result moves into the output register when it is empty or draining
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (stat.res_valid && res_ready)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && res_ready)
        begin
            m_pos_reg <= POS_W'(search_pos);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_pos_reg);

endmodule

`default_nettype wire

// File: sv/stlb_table.sv
// Table storage: one write port, one read port with registered read data.
`default_nettype none

module stlb_table #(
    parameter int DEPTH      = stlb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = stlb_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  wire                      clk,
    input  stlb_pkg::mem_ctrl_t      ctrl,
    input  wire  [ADDR_W-1:0]        wr_addr,
    input  wire  [DATA_WIDTH-1:0]    wr_data,
    input  wire  [ADDR_W-1:0]        rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    import stlb_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/stlb_search.sv
// Binary-search sequencer: one table probe per PROBE/CMP state pair over a [lo, end) window.
`default_nettype none

module stlb_search #(
    parameter int DEPTH      = stlb_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = stlb_pkg::DATA_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire  [DATA_WIDTH-1:0]    key,
    input  wire  [CW-1:0]            count,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    input  wire  [DATA_WIDTH-1:0]    rd_data,
    input  wire                      res_ready,
    output stlb_pkg::srch_stat_t     stat,
    output logic [CW-1:0]            position
);

    import stlb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         end_reg, end_next;
    logic [ADDR_W-1:0]     mid_reg, mid_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [CW:0]           mid_sum;
    logic                  hit;

    // floor((lo + hi) / 2) with hi = end - 1; only used while lo < end
    assign mid_sum = (CW + 1)'(lo_reg) + (CW + 1)'(end_reg) - (CW + 1)'(1);
    assign hit     = $signed(rd_data) >= $signed(key_reg);

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        end_next   = end_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(mid_sum >> 1);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    lo_next    = '0;
                    end_next   = count;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < end_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = rd_addr;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                // end tracks the best position so far
                if (hit)
                begin
                    end_next = CW'(mid_reg);
                end
                else
                begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
                state_next = ST_PROBE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        end_reg <= end_next;
        mid_reg <= mid_next;
        key_reg <= key_next;
    end

    assign stat.busy      = state_reg != ST_IDLE;
    assign stat.res_valid = state_reg == ST_DONE;
    assign position       = end_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("search started while busy");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_CMP) |-> lo_reg <= end_reg)
        else $error("search window inverted");

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> (CW'(mid_reg) >= lo_reg && CW'(mid_reg) < end_reg))
        else $error("probe outside window");

    a_window_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |=> (end_reg - lo_reg) < $past(end_reg - lo_reg))
        else $error("search window did not shrink");

endmodule

`default_nettype wire
